/* sv/grid_union_find_maze_carver_unit_defines.svh */
// assertion macros used by the checker file
`ifndef GRID_UNION_FIND_MAZE_CARVER_UNIT_DEFINES_SVH
`define GRID_UNION_FIND_MAZE_CARVER_UNIT_DEFINES_SVH

// same-cycle implication, disabled while reset is high
`define GUFMC_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("gufmc check failed");

// next-cycle implication, disabled while reset is high
`define GUFMC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("gufmc check failed");

`endif

/* sv/gufmc_pkg.sv */
// package: types, codes and constants of the maze carver unit
package gufmc_pkg;

   localparam int MAX_COLUMNS_DEF = 64;
   localparam int MAX_ROWS_DEF    = 64;

   // width that holds a grid limit up to the largest parameter value
   localparam int LIMIT_W = 9;

   localparam int OP_W     = 2;
   localparam int COORD_W  = 6;
   localparam int CSR_W    = 7;
   localparam int CSR_IDX_W = 2;

   localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
   localparam logic [OP_W-1:0] OP_CARVE = 2'd1;
   localparam logic [OP_W-1:0] OP_READ  = 2'd2;
   localparam logic [OP_W-1:0] OP_NONE  = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_GRID_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_HEIGHT = 2'd1;

   localparam logic [CSR_W-1:0] GRID_WIDTH_RESET  = 7'd64;
   localparam logic [CSR_W-1:0] GRID_HEIGHT_RESET = 7'd64;

   localparam logic [1:0] DIR_LEFT  = 2'd0;
   localparam logic [1:0] DIR_RIGHT = 2'd1;
   localparam logic [1:0] DIR_UP    = 2'd2;
   localparam logic [1:0] DIR_DOWN  = 2'd3;

   typedef struct packed {
      logic [OP_W-1:0]    op;
      logic [COORD_W-1:0] cell_column;
      logic [COORD_W-1:0] cell_row;
   } req_type;

   typedef struct packed {
      logic joined_left;
      logic joined_right;
      logic joined_up;
      logic joined_down;
      logic open_left;
      logic open_up;
      logic bad_cell;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic sweep_step;
      logic wall_read;
      logic dir_next;
      logic start_a;
      logic start_b;
      logic find_read;
      logic follow;
      logic save_a;
      logic link;
   } cmd_type;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            bad;
      logic            nbr_ok;
      logic            dir_last;
      logic            at_root;
      logic            roots_differ;
      logic            sweep_last;
   } status_type;

endpackage

/* sv/gufmc_ram.sv */
// generic single-port-write, single-port-read ram with registered read
module gufmc_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 4
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/gufmc_ctrl.sv */
// controller: sequences clear sweeps, parent chain walks and responses
module gufmc_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   output logic                  rsp_strobe,
   output gufmc_pkg::cmd_type    cmd,
   input  gufmc_pkg::status_type status
);

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_DECODE = 4'd1;
   localparam logic [3:0] ST_SWEEP  = 4'd2;
   localparam logic [3:0] ST_DIR    = 4'd3;
   localparam logic [3:0] ST_A_RD   = 4'd4;
   localparam logic [3:0] ST_A_CHK  = 4'd5;
   localparam logic [3:0] ST_B_RD   = 4'd6;
   localparam logic [3:0] ST_B_CHK  = 4'd7;
   localparam logic [3:0] ST_RESP   = 4'd8;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_SWEEP;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            unique case (status.op)
               gufmc_pkg::OP_CLEAR: state_in = ST_SWEEP;
               gufmc_pkg::OP_CARVE: state_in = status.bad ? ST_RESP : ST_DIR;
               gufmc_pkg::OP_READ: begin
                  cmd.wall_read = !status.bad;
                  state_in      = ST_RESP;
               end
               default: state_in = ST_RESP;
            endcase
         end
         ST_SWEEP: begin
            cmd.sweep_step = 1'b1;
            if (status.sweep_last) begin
               // the sweep after reset has no item to answer
               state_in = (status.op == gufmc_pkg::OP_CLEAR) ? ST_RESP : ST_IDLE;
            end
         end
         ST_DIR: begin
            priority if (status.nbr_ok) begin
               cmd.start_a = 1'b1;
               state_in    = ST_A_RD;
            end else if (status.dir_last) begin
               state_in = ST_RESP;
            end else begin
               cmd.dir_next = 1'b1;
            end
         end
         ST_A_RD: begin
            cmd.find_read = 1'b1;
            state_in      = ST_A_CHK;
         end
         ST_A_CHK: begin
            if (status.at_root) begin
               cmd.save_a  = 1'b1;
               cmd.start_b = 1'b1;
               state_in    = ST_B_RD;
            end else begin
               cmd.follow = 1'b1;
               state_in   = ST_A_RD;
            end
         end
         ST_B_RD: begin
            cmd.find_read = 1'b1;
            state_in      = ST_B_CHK;
         end
         ST_B_CHK: begin
            if (status.at_root) begin
               cmd.link = status.roots_differ;
               if (status.dir_last) begin
                  state_in = ST_RESP;
               end else begin
                  cmd.dir_next = 1'b1;
                  state_in     = ST_DIR;
               end
            end else begin
               cmd.follow = 1'b1;
               state_in   = ST_B_RD;
            end
         end
         ST_RESP: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = (state_ff == ST_RESP);

endmodule

/* sv/gufmc_datapath.sv */
// datapath: grid registers, cell addressing, set-link and wall memories
module gufmc_datapath #(
   parameter int MAX_COLUMNS = gufmc_pkg::MAX_COLUMNS_DEF,
   parameter int MAX_ROWS    = gufmc_pkg::MAX_ROWS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  gufmc_pkg::req_type              req_payload,
   output gufmc_pkg::rsp_type              rsp_payload,
   input  logic                            csr_write_enable,
   input  logic [gufmc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [gufmc_pkg::CSR_W-1:0]     csr_data,
   input  gufmc_pkg::cmd_type              cmd,
   output gufmc_pkg::status_type           status
);

   localparam int CELL_COUNT = MAX_COLUMNS * MAX_ROWS;
   localparam int IDX_W      = $clog2(CELL_COUNT);
   localparam logic [IDX_W-1:0] CELL_LAST = IDX_W'(CELL_COUNT - 1);
   localparam logic [IDX_W-1:0] ROW_STEP  = IDX_W'(MAX_COLUMNS);
   localparam logic [gufmc_pkg::LIMIT_W-1:0] COL_LIMIT = gufmc_pkg::LIMIT_W'(MAX_COLUMNS);
   localparam logic [gufmc_pkg::LIMIT_W-1:0] ROW_LIMIT = gufmc_pkg::LIMIT_W'(MAX_ROWS);

   logic [gufmc_pkg::CSR_W-1:0]     grid_width_ff;
   logic [gufmc_pkg::CSR_W-1:0]     grid_height_ff;
   logic [gufmc_pkg::OP_W-1:0]      op_ff;
   logic [IDX_W-1:0]                count_ff;
   logic                            bad_ff;
   logic [gufmc_pkg::COORD_W-1:0]   col_ff;
   logic [gufmc_pkg::COORD_W-1:0]   row_ff;
   logic [IDX_W-1:0]                cell_ff;
   logic [IDX_W-1:0]                cur_ff;
   logic [IDX_W-1:0]                ra_ff;
   logic [1:0]                      dir_ff;
   logic [3:0]                      joined_ff;

   logic [gufmc_pkg::LIMIT_W-1:0]   cols;
   logic [gufmc_pkg::LIMIT_W-1:0]   rows;
   logic [gufmc_pkg::LIMIT_W-1:0]   col_ext;
   logic [gufmc_pkg::LIMIT_W-1:0]   row_ext;
   logic [gufmc_pkg::LIMIT_W-1:0]   req_col_ext;
   logic [gufmc_pkg::LIMIT_W-1:0]   req_row_ext;
   logic                            bad_in;
   logic [IDX_W-1:0]                cell_in;
   logic [IDX_W-1:0]                nbr;
   logic                            nbr_ok;

   logic                            parent_we;
   logic [IDX_W-1:0]                parent_waddr;
   logic [IDX_W-1:0]                parent_wdata;
   logic [IDX_W-1:0]                parent_rdata;
   logic                            wall_link_up;
   logic [IDX_W-1:0]                wall_addr;
   logic                            left_we;
   logic                            up_we;
   logic [IDX_W-1:0]                wall_waddr;
   logic                            left_rdata;
   logic                            up_rdata;
   logic                            is_read;

   // grid in use is clipped to the array size
   assign cols = ({2'b00, grid_width_ff} < COL_LIMIT) ? {2'b00, grid_width_ff} : COL_LIMIT;
   assign rows = ({2'b00, grid_height_ff} < ROW_LIMIT) ? {2'b00, grid_height_ff} : ROW_LIMIT;

   assign req_col_ext = gufmc_pkg::LIMIT_W'(req_payload.cell_column);
   assign req_row_ext = gufmc_pkg::LIMIT_W'(req_payload.cell_row);
   assign col_ext     = gufmc_pkg::LIMIT_W'(col_ff);
   assign row_ext     = gufmc_pkg::LIMIT_W'(row_ff);

   assign bad_in  = ((req_payload.op == gufmc_pkg::OP_CARVE) ||
                     (req_payload.op == gufmc_pkg::OP_READ)) &&
                    ((req_col_ext >= cols) || (req_row_ext >= rows));
   assign cell_in = IDX_W'(int'(req_payload.cell_row) * MAX_COLUMNS +
                           int'(req_payload.cell_column));

   always_comb begin
      unique case (dir_ff)
         gufmc_pkg::DIR_LEFT: begin
            nbr    = cell_ff - IDX_W'(1);
            nbr_ok = (col_ff != '0);
         end
         gufmc_pkg::DIR_RIGHT: begin
            nbr    = cell_ff + IDX_W'(1);
            nbr_ok = ((col_ext + gufmc_pkg::LIMIT_W'(1)) < cols);
         end
         gufmc_pkg::DIR_UP: begin
            nbr    = cell_ff - ROW_STEP;
            nbr_ok = (row_ff != '0);
         end
         default: begin
            nbr    = cell_ff + ROW_STEP;
            nbr_ok = ((row_ext + gufmc_pkg::LIMIT_W'(1)) < rows);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff  <= gufmc_pkg::GRID_WIDTH_RESET;
         grid_height_ff <= gufmc_pkg::GRID_HEIGHT_RESET;
         op_ff          <= gufmc_pkg::OP_NONE;
         count_ff       <= '0;
      end else begin
         if (csr_write_enable && (csr_index == gufmc_pkg::CSR_GRID_WIDTH)) begin
            grid_width_ff <= csr_data;
         end
         if (csr_write_enable && (csr_index == gufmc_pkg::CSR_GRID_HEIGHT)) begin
            grid_height_ff <= csr_data;
         end
         if (cmd.load) begin
            op_ff <= req_payload.op;
         end
         if (cmd.sweep_step) begin
            count_ff <= (count_ff == CELL_LAST) ? '0 : count_ff + IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         bad_ff    <= bad_in;
         col_ff    <= req_payload.cell_column;
         row_ff    <= req_payload.cell_row;
         cell_ff   <= cell_in;
         dir_ff    <= gufmc_pkg::DIR_LEFT;
         joined_ff <= '0;
      end
      if (cmd.dir_next) begin
         dir_ff <= dir_ff + 2'd1;
      end
      priority if (cmd.start_a) begin
         cur_ff <= cell_ff;
      end else if (cmd.start_b) begin
         cur_ff <= nbr;
      end else if (cmd.follow) begin
         cur_ff <= parent_rdata;
      end
      if (cmd.save_a) begin
         ra_ff <= cur_ff;
      end
      if (cmd.link) begin
         joined_ff[dir_ff] <= 1'b1;
      end
   end

   // root of the carved cell takes the neighbor root as parent
   assign parent_we    = cmd.sweep_step | cmd.link;
   assign parent_waddr = cmd.sweep_step ? count_ff : ra_ff;
   assign parent_wdata = cmd.sweep_step ? count_ff : cur_ff;

   gufmc_ram #(
      .WIDTH (IDX_W),
      .DEPTH (CELL_COUNT)
   ) u_parent_ram (
      .clock   (clock),
      .wr_en   (parent_we),
      .wr_addr (parent_waddr),
      .wr_data (parent_wdata),
      .rd_en   (cmd.find_read),
      .rd_addr (cur_ff),
      .rd_data (parent_rdata)
   );

   // right and down merges open the wall stored at the neighbor
   assign wall_link_up = dir_ff[1];
   assign wall_addr    = dir_ff[0] ? nbr : cell_ff;
   assign wall_waddr   = cmd.sweep_step ? count_ff : wall_addr;
   assign left_we      = cmd.sweep_step | (cmd.link & !wall_link_up);
   assign up_we        = cmd.sweep_step | (cmd.link & wall_link_up);

   gufmc_ram #(
      .WIDTH (1),
      .DEPTH (CELL_COUNT)
   ) u_left_ram (
      .clock   (clock),
      .wr_en   (left_we),
      .wr_addr (wall_waddr),
      .wr_data (!cmd.sweep_step),
      .rd_en   (cmd.wall_read),
      .rd_addr (cell_ff),
      .rd_data (left_rdata)
   );

   gufmc_ram #(
      .WIDTH (1),
      .DEPTH (CELL_COUNT)
   ) u_up_ram (
      .clock   (clock),
      .wr_en   (up_we),
      .wr_addr (wall_waddr),
      .wr_data (!cmd.sweep_step),
      .rd_en   (cmd.wall_read),
      .rd_addr (cell_ff),
      .rd_data (up_rdata)
   );

   assign is_read = (op_ff == gufmc_pkg::OP_READ) && !bad_ff;

   assign rsp_payload.joined_left  = joined_ff[gufmc_pkg::DIR_LEFT];
   assign rsp_payload.joined_right = joined_ff[gufmc_pkg::DIR_RIGHT];
   assign rsp_payload.joined_up    = joined_ff[gufmc_pkg::DIR_UP];
   assign rsp_payload.joined_down  = joined_ff[gufmc_pkg::DIR_DOWN];
   assign rsp_payload.open_left    = is_read & left_rdata;
   assign rsp_payload.open_up      = is_read & up_rdata;
   assign rsp_payload.bad_cell     = bad_ff;

   assign status.op           = op_ff;
   assign status.bad          = bad_ff;
   assign status.nbr_ok       = nbr_ok;
   assign status.dir_last     = (dir_ff == gufmc_pkg::DIR_DOWN);
   assign status.at_root      = (parent_rdata == cur_ff);
   assign status.roots_differ = (ra_ff != cur_ff);
   assign status.sweep_last   = (count_ff == CELL_LAST);

endmodule

/* sv/grid_union_find_maze_carver_unit.sv */
// top level: union-find maze carver over a cell grid
//
// channel   ports                                  transfer
// request   start, busy, req_payload               start high while busy low
// result    rsp_strobe, rsp_payload                every cycle rsp_strobe is high
// config    csr_write_enable, csr_index, csr_data  every cycle the enable is high
//
// one item at a time; read, unused op and bad cell: result 2 cycles after the transfer,
//   and the next transfer can come one cycle after the result
// carve: 2 cycles plus 1 for each neighbor outside the grid and, for each neighbor in the
//   grid, 2*(da+db)+5 cycles, da and db being the links followed by the two finds
// clear: MAX_COLUMNS*MAX_ROWS+2 cycles, one cell a cycle through the link and wall memories;
//   reset runs the same pass with busy high and gives no result
// results cannot be held off; config writes go straight to the grid registers
module grid_union_find_maze_carver_unit #(
   parameter int MAX_COLUMNS = gufmc_pkg::MAX_COLUMNS_DEF,
   parameter int MAX_ROWS    = gufmc_pkg::MAX_ROWS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  gufmc_pkg::req_type              req_payload,
   output logic                            rsp_strobe,
   output gufmc_pkg::rsp_type              rsp_payload,
   input  logic                            csr_write_enable,
   input  logic [gufmc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [gufmc_pkg::CSR_W-1:0]     csr_data
);

   gufmc_pkg::cmd_type    cmd;
   gufmc_pkg::status_type status;

   gufmc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .cmd        (cmd),
      .status     (status)
   );

   gufmc_datapath #(
      .MAX_COLUMNS (MAX_COLUMNS),
      .MAX_ROWS    (MAX_ROWS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_payload      (req_payload),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .cmd              (cmd),
      .status           (status)
   );

endmodule

/* sv/gufmc_checker.sv */
// port-level checker for the maze carver unit, bound to the top level
`include "grid_union_find_maze_carver_unit_defines.svh"

module gufmc_checker (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic               rsp_strobe,
   input gufmc_pkg::rsp_type rsp_payload
);

   logic any_joined;
   logic any_open;
   logic fields_ok;

   assign any_joined = rsp_payload.joined_left | rsp_payload.joined_right |
                       rsp_payload.joined_up | rsp_payload.joined_down;
   assign any_open   = rsp_payload.open_left | rsp_payload.open_up;
   assign fields_ok  = !(rsp_payload.bad_cell && (any_joined || any_open)) &&
                       !(any_joined && any_open);

   // a transfer always leaves the block busy until its result
   `GUFMC_ASSERT_NEXT(a_busy_after_transfer, clock, reset, start && !busy, busy)

   // a result is shown for one cycle and the block is free right after
   `GUFMC_ASSERT_NEXT(a_free_after_result, clock, reset, rsp_strobe, !rsp_strobe && !busy)

   // a result only appears while an item is still held
   `GUFMC_ASSERT_NOW(a_result_while_busy, clock, reset, rsp_strobe, busy)

   // a bad cell reports nothing else, and carve and read flags never mix
   `GUFMC_ASSERT_NOW(a_result_fields, clock, reset, rsp_strobe, fields_ok)

endmodule

bind grid_union_find_maze_carver_unit gufmc_checker u_gufmc_checker (.*);

/* bench/grid_union_find_maze_carver_unit_test.sv */
// testbench for the union-find maze carver: queued command driver, predictor and result checker
module grid_union_find_maze_carver_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int COLS_MAX     = gufmc_pkg::MAX_COLUMNS_DEF;
   localparam int ROWS_MAX     = gufmc_pkg::MAX_ROWS_DEF;
   localparam int CELLS        = COLS_MAX * ROWS_MAX;
   localparam int RANDOM_ITEMS = 700;
   localparam int STALL_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 64;
   localparam int MAX_REPORTS  = 10;

   // register indexes with no register behind them
   localparam logic [gufmc_pkg::CSR_IDX_W-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [gufmc_pkg::CSR_IDX_W-1:0] CSR_SPARE_B = 2'd3;

   logic                            clock            = 1'b0;
   logic                            reset            = 1'b1;
   logic                            start            = 1'b0;
   logic                            busy;
   gufmc_pkg::req_type              req_payload      = '0;
   logic                            rsp_strobe;
   gufmc_pkg::rsp_type              rsp_payload;
   logic                            csr_write_enable = 1'b0;
   logic [gufmc_pkg::CSR_IDX_W-1:0] csr_index        = '0;
   logic [gufmc_pkg::CSR_W-1:0]     csr_data         = '0;

   // predictor copy of the forest, the walls and the grid registers
   int                          set_parent [CELLS];
   logic [1:0]                  wall_flags [CELLS];
   logic [gufmc_pkg::CSR_W-1:0] grid_cols_reg;
   logic [gufmc_pkg::CSR_W-1:0] grid_rows_reg;

   gufmc_pkg::req_type maze_cmds[$];
   gufmc_pkg::rsp_type maze_outcomes[$];
   gufmc_pkg::rsp_type want;
   string   diff_fields;
   int      mismatch_count = 0;
   int      stall_cycles   = 0;
   int      idle_odds      = 0;
   int      idle_left      = 0;
   int      counted_items  = 0;
   logic    req_taken      = 1'b0;

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   grid_union_find_maze_carver_unit dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_payload      (req_payload),
      .rsp_strobe       (rsp_strobe),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   function automatic void forest_clear();
      for (int i = 0; i < CELLS; i++) begin
         set_parent[i] = i;
         wall_flags[i] = 2'b00;
      end
   endfunction

   function automatic int root_of_cell(int c);
      int r;
      r = c;
      for (int steps = 0; steps < CELLS && set_parent[r] != r; steps++)
         r = set_parent[r];
      return r;
   endfunction

   // root of the carved cell hangs under the neighbor's root
   function automatic bit merge_cells(int a, int b);
      int ra;
      int rb;
      ra = root_of_cell(a);
      rb = root_of_cell(b);
      if (ra == rb)
         return 1'b0;
      set_parent[ra] = rb;
      return 1'b1;
   endfunction

   function automatic gufmc_pkg::rsp_type maze_outcome(gufmc_pkg::req_type cmd);
      gufmc_pkg::rsp_type res;
      int      cols;
      int      rows;
      int      col;
      int      row;
      int      cell_idx;
      res  = '0;
      cols = (grid_cols_reg < COLS_MAX) ? int'(grid_cols_reg) : COLS_MAX;
      rows = (grid_rows_reg < ROWS_MAX) ? int'(grid_rows_reg) : ROWS_MAX;
      col  = int'(cmd.cell_column);
      row  = int'(cmd.cell_row);
      if (cmd.op == gufmc_pkg::OP_CLEAR) begin
         forest_clear();
      end else if (cmd.op != gufmc_pkg::OP_NONE) begin
         if (col >= cols || row >= rows) begin
            res.bad_cell = 1'b1;
         end else begin
            cell_idx = row * COLS_MAX + col;
            if (cmd.op == gufmc_pkg::OP_READ) begin
               res.open_left = wall_flags[cell_idx][0];
               res.open_up   = wall_flags[cell_idx][1];
            end else begin
               if (col >= 1 && merge_cells(cell_idx, cell_idx - 1)) begin
                  wall_flags[cell_idx][0] = 1'b1;
                  res.joined_left         = 1'b1;
               end
               if (col + 1 < cols && merge_cells(cell_idx, cell_idx + 1)) begin
                  wall_flags[cell_idx + 1][0] = 1'b1;
                  res.joined_right            = 1'b1;
               end
               if (row >= 1 && merge_cells(cell_idx, cell_idx - COLS_MAX)) begin
                  wall_flags[cell_idx][1] = 1'b1;
                  res.joined_up           = 1'b1;
               end
               if (row + 1 < rows && merge_cells(cell_idx, cell_idx + COLS_MAX)) begin
                  wall_flags[cell_idx + COLS_MAX][1] = 1'b1;
                  res.joined_down                    = 1'b1;
               end
            end
         end
      end
      return res;
   endfunction

   function automatic string show_outcome(gufmc_pkg::rsp_type r);
      return $sformatf("jl=%b jr=%b ju=%b jd=%b ol=%b ou=%b bad=%b", r.joined_left,
                       r.joined_right, r.joined_up, r.joined_down, r.open_left, r.open_up,
                       r.bad_cell);
   endfunction

   // command driver: holds start until the transfer, then maybe idles a burst
   always @(negedge clock) begin
      if (reset) begin
         start     <= 1'b0;
         idle_left <= 0;
      end else if (!start || req_taken) begin
         if (idle_left > 0 && idle_odds != 0) begin
            start     <= 1'b0;
            idle_left <= idle_left - 1;
         end else if (maze_cmds.size() > 0) begin
            req_payload <= maze_cmds.pop_front();
            start       <= 1'b1;
            if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1)
               idle_left <= $urandom_range(1, 12);
         end else begin
            start <= 1'b0;
         end
      end
   end

   // result checker and predictor, both on the rising edge
   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         if (rsp_strobe === 1'b1) begin
            if (maze_outcomes.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("%0t: result with none expected: %s", $time,
                           show_outcome(rsp_payload));
            end else begin
               want        = maze_outcomes.pop_front();
               diff_fields = "";
               if (rsp_payload.joined_left !== want.joined_left)
                  diff_fields = {diff_fields, " joined_left"};
               if (rsp_payload.joined_right !== want.joined_right)
                  diff_fields = {diff_fields, " joined_right"};
               if (rsp_payload.joined_up !== want.joined_up)
                  diff_fields = {diff_fields, " joined_up"};
               if (rsp_payload.joined_down !== want.joined_down)
                  diff_fields = {diff_fields, " joined_down"};
               if (rsp_payload.open_left !== want.open_left)
                  diff_fields = {diff_fields, " open_left"};
               if (rsp_payload.open_up !== want.open_up)
                  diff_fields = {diff_fields, " open_up"};
               if (rsp_payload.bad_cell !== want.bad_cell)
                  diff_fields = {diff_fields, " bad_cell"};
               if (diff_fields != "") begin
                  mismatch_count++;
                  if (mismatch_count <= MAX_REPORTS)
                     $display("%0t: mismatch in%s: expected %s, got %s", $time, diff_fields,
                              show_outcome(want), show_outcome(rsp_payload));
               end
            end
         end
         req_taken <= start && !busy;
         if (start && !busy)
            maze_outcomes.push_back(maze_outcome(req_payload));
      end
   end

   always @(posedge clock) begin
      if ((start && !busy) || rsp_strobe)
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("no transfer for %0d cycles", stall_cycles);
         $display("CHECK FAILED");
         $finish;
      end
   end

   task automatic push_cmd(logic [gufmc_pkg::OP_W-1:0] op, int col, int row);
      gufmc_pkg::req_type cmd;
      cmd.op          = op;
      cmd.cell_column = col[gufmc_pkg::COORD_W-1:0];
      cmd.cell_row    = row[gufmc_pkg::COORD_W-1:0];
      maze_cmds.push_back(cmd);
      if (op != gufmc_pkg::OP_NONE)
         counted_items++;
   endtask

   // idle means nothing queued, nothing in flight and busy low
   task automatic wait_quiet();
      logic quiet;
      quiet = 1'b0;
      while (!quiet) begin
         @(posedge clock);
         if (maze_cmds.size() == 0 && !start && maze_outcomes.size() == 0) begin
            @(negedge clock);
            quiet = (busy === 1'b0);
         end
      end
   endtask

   task automatic write_reg(logic [gufmc_pkg::CSR_IDX_W-1:0] idx,
                            logic [gufmc_pkg::CSR_W-1:0] val);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_data         <= val;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      if (idx == gufmc_pkg::CSR_GRID_WIDTH)
         grid_cols_reg = val;
      else if (idx == gufmc_pkg::CSR_GRID_HEIGHT)
         grid_rows_reg = val;
   endtask

   task automatic set_grid(logic [gufmc_pkg::CSR_W-1:0] w, logic [gufmc_pkg::CSR_W-1:0] h);
      wait_quiet();
      write_reg(gufmc_pkg::CSR_GRID_WIDTH, w);
      write_reg(gufmc_pkg::CSR_GRID_HEIGHT, h);
   endtask

   // stray commands: unused op, full-range cells that often miss the grid, rare clear
   task automatic noise_cmd();
      case ($urandom_range(0, 9))
         0: push_cmd(gufmc_pkg::OP_NONE, $urandom_range(0, 63), $urandom_range(0, 63));
         1: begin
            if ($urandom_range(0, 5) == 0)
               push_cmd(gufmc_pkg::OP_CLEAR, $urandom_range(0, 63), $urandom_range(0, 63));
            else
               push_cmd(gufmc_pkg::OP_READ, $urandom_range(0, 63), $urandom_range(0, 63));
         end
         default: push_cmd($urandom_range(0, 1) ? gufmc_pkg::OP_CARVE : gufmc_pkg::OP_READ,
                           $urandom_range(0, 63), $urandom_range(0, 63));
      endcase
   endtask

   // kruskal pass: every cell carved once in shuffled order, reads and noise mixed in
   task automatic sweep_grid(int cols, int rows);
      int order[$];
      int pick;
      int tmp;
      for (int i = 0; i < cols * rows; i++)
         order.push_back((i / cols) * COLS_MAX + i % cols);
      for (int i = order.size() - 1; i > 0; i--) begin
         pick        = $urandom_range(0, i);
         tmp         = order[i];
         order[i]    = order[pick];
         order[pick] = tmp;
      end
      foreach (order[i]) begin
         push_cmd(gufmc_pkg::OP_CARVE, order[i] % COLS_MAX, order[i] / COLS_MAX);
         if ($urandom_range(0, 7) == 0)
            push_cmd(gufmc_pkg::OP_READ, $urandom_range(0, cols - 1),
                     $urandom_range(0, rows - 1));
         if ($urandom_range(0, 11) == 0)
            noise_cmd();
      end
      for (int i = 0; i < cols * rows; i++)
         if ($urandom_range(0, 1) == 1)
            push_cmd(gufmc_pkg::OP_READ, i % cols, i / cols);
   endtask

   initial begin : stimulus
      int shape;
      int w;
      int h;
      int random_floor;

      forest_clear();
      grid_cols_reg = gufmc_pkg::GRID_WIDTH_RESET;
      grid_rows_reg = gufmc_pkg::GRID_HEIGHT_RESET;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // corners, repeated carve, unused op, clear with junk cell fields
      wait_quiet();
      push_cmd(gufmc_pkg::OP_READ, 0, 0);
      push_cmd(gufmc_pkg::OP_READ, 63, 63);
      push_cmd(gufmc_pkg::OP_CARVE, 0, 0);
      push_cmd(gufmc_pkg::OP_CARVE, 63, 63);
      push_cmd(gufmc_pkg::OP_READ, 1, 0);
      push_cmd(gufmc_pkg::OP_READ, 0, 1);
      push_cmd(gufmc_pkg::OP_READ, 63, 63);
      push_cmd(gufmc_pkg::OP_CARVE, 0, 0);
      push_cmd(gufmc_pkg::OP_CARVE, 1, 1);
      push_cmd(gufmc_pkg::OP_NONE, 63, 63);
      push_cmd(gufmc_pkg::OP_CLEAR, 63, 63);
      push_cmd(gufmc_pkg::OP_READ, 1, 0);

      // zero width leaves no cell at all
      set_grid(0, 64);
      push_cmd(gufmc_pkg::OP_CARVE, 0, 0);
      push_cmd(gufmc_pkg::OP_READ, 0, 0);

      // oversized width clamps, single row
      set_grid(127, 1);
      push_cmd(gufmc_pkg::OP_CARVE, 5, 0);
      push_cmd(gufmc_pkg::OP_READ, 6, 0);
      push_cmd(gufmc_pkg::OP_READ, 5, 1);
      push_cmd(gufmc_pkg::OP_CARVE, 63, 0);

      set_grid(1, 1);
      push_cmd(gufmc_pkg::OP_CARVE, 0, 0);
      push_cmd(gufmc_pkg::OP_CARVE, 1, 0);

      // writes to the spare indexes must not move the grid
      wait_quiet();
      write_reg(CSR_SPARE_A, 7'h7f);
      write_reg(CSR_SPARE_B, 7'h7f);
      push_cmd(gufmc_pkg::OP_CARVE, 0, 0);

      // shrink then grow: cells outside keep their state
      set_grid(2, 2);
      push_cmd(gufmc_pkg::OP_CARVE, 0, 0);
      push_cmd(gufmc_pkg::OP_CARVE, 1, 1);
      set_grid(64, 127);
      push_cmd(gufmc_pkg::OP_READ, 1, 1);
      push_cmd(gufmc_pkg::OP_CARVE, 1, 1);
      push_cmd(gufmc_pkg::OP_READ, 2, 1);

      random_floor = counted_items;
      while (counted_items - random_floor < RANDOM_ITEMS) begin
         shape = $urandom_range(0, 11);
         case (shape)
            0: begin
               w = $urandom_range(64, 127);
               h = $urandom_range(1, 2);
            end
            1: begin
               w = $urandom_range(1, 2);
               h = $urandom_range(64, 127);
            end
            2: begin
               w = 64;
               h = 64;
            end
            3: begin
               if ($urandom_range(0, 1) == 1) begin
                  w = 0;
                  h = $urandom_range(0, 127);
               end else begin
                  w = $urandom_range(1, 127);
                  h = 0;
               end
            end
            default: begin
               w = $urandom_range(1, 8);
               h = $urandom_range(1, 8);
            end
         endcase
         set_grid(gufmc_pkg::CSR_W'(w), gufmc_pkg::CSR_W'(h));
         case ($urandom_range(0, 2))
            0: idle_odds = 0;
            1: idle_odds = 2;
            default: idle_odds = 5;
         endcase
         if (shape == 2 || $urandom_range(0, 2) != 0)
            push_cmd(gufmc_pkg::OP_CLEAR, $urandom_range(0, 63), $urandom_range(0, 63));
         w = (w < COLS_MAX) ? w : COLS_MAX;
         h = (h < ROWS_MAX) ? h : ROWS_MAX;
         if (shape == 3) begin
            repeat (8) noise_cmd();
         end else if (shape == 2) begin
            // full grid kept sparse so parent chains stay short
            repeat (60)
               push_cmd($urandom_range(0, 2) != 0 ? gufmc_pkg::OP_CARVE : gufmc_pkg::OP_READ,
                        $urandom_range(0, 63), $urandom_range(0, 63));
         end else begin
            sweep_grid(w, h);
         end
      end

      // closing stretch without idle bursts
      set_grid(4, 4);
      idle_odds = 0;
      push_cmd(gufmc_pkg::OP_CLEAR, 0, 0);
      sweep_grid(4, 4);

      wait_quiet();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && maze_outcomes.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

/* grid_union_find_maze_carver_unit.f */
+incdir+sv
sv/gufmc_pkg.sv
sv/gufmc_ram.sv
sv/gufmc_ctrl.sv
sv/gufmc_datapath.sv
sv/grid_union_find_maze_carver_unit.sv
sv/gufmc_checker.sv
bench/grid_union_find_maze_carver_unit_test.sv
